// ===== hdl/csm_pkg.sv =====
// ----------------------------------------------------------------------------
// csm_pkg: shared types and constants of the caseless substring matcher
// Pattern and position sizes, configuration register indexes, letter folding.
// ----------------------------------------------------------------------------
package csm_pkg;

  // Pattern sizing
  localparam int unsigned PatternMax = 16;
  localparam int unsigned IdxBits    = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int unsigned LenBits    = 5;

  // Position and count sizing
  localparam int unsigned PosBits   = 16;
  localparam int unsigned CountBits = 16;
  localparam logic [PosBits-1:0]   PosMax   = {PosBits{1'b1}};
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Configuration register indexes
  localparam int unsigned CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] CfgLength = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgFirst  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgLast   = 2'd2;
  localparam int unsigned CfgDataBits = 64;

  // Letter constants
  localparam logic [7:0] UpperA = 8'h41;
  localparam logic [7:0] UpperZ = 8'h5A;
  localparam logic [7:0] LowerA = 8'h61;

  typedef logic [7:0] byte_t;

  // Decoded pattern handed from the register block to the compare window
  typedef struct packed {
    logic [LenBits-1:0]         len;
    byte_t [PatternMax-1:0]     pattern;
  } cfg_t;

  // Fold A..Z to lower case, every other byte unchanged
  function automatic byte_t fold_letter(input byte_t b);
    byte_t r;
    r = b;
    if (b >= UpperA && b <= UpperZ) begin
      r = b - UpperA + LowerA;
    end
    return r;
  endfunction

endpackage

// ===== hdl/caseless_substring_matcher.sv =====
// ----------------------------------------------------------------------------
// caseless_substring_matcher: case-insensitive non-overlapping pattern search
// Searches a byte stream for a pattern of up to 16 bytes and reports one
// result per byte with match flag, positions and running count.
// ----------------------------------------------------------------------------
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   text     | text_valid_i/ready_o, byte, last          | in
//   result   | result_valid_o/ready_i, match, pos, count | out
//   config   | cfg_we_i, cfg_index_i, cfg_data_i         | in
//
// One byte per cycle while the result side does not stall; a text byte passes
// the input register and then the result register on its way to the result.
// The compare, position and count update sit in the combinational logic between them.
// Reset clears the window, position, count and handshake state at once.
// A stalled result holds the input register, which then holds text_ready_o.
// ----------------------------------------------------------------------------
module caseless_substring_matcher import csm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   text_valid_i,
  output logic                   text_ready_o,
  input  logic [7:0]             text_byte_i,
  input  logic                   text_last_i,
  output logic                   result_valid_o,
  input  logic                   result_ready_i,
  output logic                   match_found_o,
  output logic [15:0]            match_start_o,
  output logic [15:0]            match_end_o,
  output logic [15:0]            match_total_o,
  output logic                   text_done_o
);

  cfg_t cfg;
  logic win_hit;

  // Input register
  logic  in_valid_q;
  byte_t in_byte_q;
  logic  in_last_q;
  logic  advance;

  // Text state
  logic [PosBits-1:0]   pos_q, pos_d, pos_inc;
  logic [LenBits-1:0]   blocked_q, blocked_d;
  logic [CountBits-1:0] count_q, count_d, count_step;
  logic [PosBits-1:0]   len_ext;
  logic                 hit_ok;
  logic [PosBits-1:0]   start_step;

  // Result register
  logic                 res_valid_q;
  logic                 found_q;
  logic [PosBits-1:0]   start_q, end_q;
  logic [CountBits-1:0] total_q;
  logic                 done_q;

  csm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  csm_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (advance),
    .clear_i (in_last_q),
    .byte_i  (in_byte_q),
    .cfg_i   (cfg),
    .hit_o   (win_hit)
  );

  // Handshake: the held byte moves on whenever the result slot frees
  assign advance      = in_valid_q && (!res_valid_q || result_ready_i);
  assign text_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (text_ready_o) begin
      in_valid_q <= text_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_ready_o && text_valid_i) begin
      in_byte_q <= fold_letter(text_byte_i);
      in_last_q <= text_last_i;
    end
  end

  // Step: position, blocked span, match and count
  always_comb begin
    pos_inc    = (pos_q != PosMax) ? pos_q + PosBits'(1) : pos_q;
    len_ext    = PosBits'(cfg.len);
    hit_ok     = (blocked_q == '0) && (pos_inc >= len_ext) && win_hit;
    start_step = hit_ok ? pos_inc - len_ext + PosBits'(1) : '0;
    count_step = (hit_ok && count_q != CountMax) ? count_q + CountBits'(1) : count_q;
    if (blocked_q != '0) begin
      blocked_d = blocked_q - LenBits'(1);
    end else if (hit_ok) begin
      blocked_d = cfg.len - LenBits'(1);
    end else begin
      blocked_d = '0;
    end
    pos_d   = pos_inc;
    count_d = count_step;
    // End of text: start afresh for the next one
    if (in_last_q) begin
      pos_d     = '0;
      blocked_d = '0;
      count_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      blocked_q <= '0;
      count_q   <= '0;
    end else if (advance) begin
      pos_q     <= pos_d;
      blocked_q <= blocked_d;
      count_q   <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      found_q <= hit_ok;
      start_q <= start_step;
      end_q   <= hit_ok ? pos_inc : '0;
      total_q <= count_step;
      done_q  <= in_last_q;
    end
  end

  assign result_valid_o = res_valid_q;
  assign match_found_o  = found_q;
  assign match_start_o  = start_q;
  assign match_end_o    = end_q;
  assign match_total_o  = total_q;
  assign text_done_o    = done_q;

endmodule

// ===== hdl/csm_cfg.sv =====
// ----------------------------------------------------------------------------
// csm_cfg: configuration registers
// Holds pattern length and pattern words, clamps the length and folds the
// pattern bytes for the compare window.
// ----------------------------------------------------------------------------
module csm_cfg import csm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [LenBits-1:0]     len_q;
  logic [CfgDataBits-1:0] first_q;
  logic [CfgDataBits-1:0] last_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LenBits'(1);
      first_q <= '0;
      last_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgLength: len_q   <= cfg_data_i[LenBits-1:0];
        CfgFirst:  first_q <= cfg_data_i;
        CfgLast:   last_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Length in use and folded pattern bytes
  always_comb begin
    if (len_q == '0) begin
      cfg_o.len = LenBits'(1);
    end else if (len_q > LenBits'(PatternMax)) begin
      cfg_o.len = LenBits'(PatternMax);
    end else begin
      cfg_o.len = len_q;
    end
    for (int k = 0; k < PatternMax; k++) begin
      cfg_o.pattern[k] = fold_letter((k < 8) ? first_q[8*(k%8) +: 8]
                                             : last_q[8*(k%8) +: 8]);
    end
  end

endmodule

// ===== hdl/csm_window.sv =====
// ----------------------------------------------------------------------------
// csm_window: recent text bytes and pattern compare
// Shift line of folded text bytes, newest first, and a parallel compare of
// the window including the incoming byte against the pattern.
// ----------------------------------------------------------------------------
module csm_window import csm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  logic  clear_i,
  input  byte_t byte_i,
  input  cfg_t  cfg_i,
  output logic  hit_o
);

  byte_t [PatternMax-1:0] recent_q;
  byte_t [PatternMax-1:0] win;

  // Window as it stands once the incoming byte is in
  always_comb begin
    win[0] = byte_i;
    for (int j = 1; j < PatternMax; j++) begin
      win[j] = recent_q[j-1];
    end
  end

  // Pattern byte k lines up with window slot len-1-k
  always_comb begin
    logic [IdxBits-1:0] pidx;
    hit_o = 1'b1;
    pidx  = '0;
    for (int j = 0; j < PatternMax; j++) begin
      pidx = IdxBits'(cfg_i.len - LenBits'(j) - LenBits'(1));
      if (LenBits'(j) < cfg_i.len && win[j] != cfg_i.pattern[pidx]) begin
        hit_o = 1'b0;
      end
    end
  end

  // Shift line, cleared at the end of a text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
    end else if (shift_i) begin
      if (clear_i) begin
        recent_q <= '0;
      end else begin
        recent_q <= win;
      end
    end
  end

endmodule
